>>> sv/i2cms_pkg.sv
package i2cms_pkg;

  localparam logic [15:0] DELAY_RESET   = 16'd500;
  localparam logic [2:0]  BYTE_MSB      = 3'd7;
  localparam logic [3:0]  BITS_PER_BYTE = 4'd8;
  localparam int          QDEPTH        = 2;
  localparam int          ADDR_W        = 3;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    REG_EDGE_DELAY = 1'b0,
    REG_UNUSED     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic       command_valid;
    logic [1:0] command;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       scl_in;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
  } out_item_t;

  typedef struct packed {
    logic       cmd_valid;
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       scl_in;
    logic       sda_in;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

endpackage

>>> sv/i2cms_front.sv
module i2cms_front
  import i2cms_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output q_head_t  head,
  input  logic     head_pop
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  q_item_t            queue_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               push;
  logic               pop;
  q_item_t            classified;

  assign in_ready = (count_r != CNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = head_pop && (count_r != '0);

  always_comb begin
    classified.cmd_valid = in_data.command_valid;
    classified.cmd       = cmd_t'(in_data.command);
    classified.tx_byte   = in_data.tx_byte;
    classified.send_ack  = in_data.send_ack;
    classified.scl_in    = in_data.scl_in;
    classified.sda_in    = in_data.sda_in;
  end

  assign head.valid = (count_r != '0);
  assign head.item  = queue_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> sv/i2cms_back.sv
module i2cms_back
  import i2cms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] edge_delay,
  input  q_head_t     head,
  output logic        head_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_W, PH_ST_D1, PH_ST_D2, PH_ST_D3,
    PH_SP_D1, PH_SP_W, PH_SP_D2, PH_SP_D3,
    PH_WR_D1, PH_WR_W, PH_WR_D2, PH_WR_AD1, PH_WR_AW, PH_WR_AD2,
    PH_RD_W, PH_RD_D1, PH_RD_D2, PH_RD_AD1, PH_RD_AW, PH_RD_AD2
  } phase_t;

  phase_t      phase_r,  phase_nxt;
  cmd_t        active_r, active_nxt;
  logic [3:0]  bit_r,    bit_nxt;
  logic [15:0] wait_r,   wait_nxt;
  logic [7:0]  shift_r,  shift_nxt;
  logic        acks_r,   acks_nxt;
  logic        seen_r,   seen_nxt;
  logic        scl_r,    scl_nxt;
  logic        sda_r,    sda_nxt;
  logic        out_valid_r;
  out_item_t   out_data_r;
  out_item_t   res;
  logic        advance;
  logic        done;
  logic        is_wait;
  logic        fire;
  q_item_t     q;

  assign q        = head.item;
  assign head_pop = !out_valid_r || out_ready;
  assign fire     = head.valid && head_pop;

  assign is_wait = (phase_r == PH_ST_W) || (phase_r == PH_SP_W) || (phase_r == PH_WR_W) ||
                   (phase_r == PH_WR_AW) || (phase_r == PH_RD_W) || (phase_r == PH_RD_AW);

  always_comb begin
    phase_nxt  = phase_r;
    active_nxt = active_r;
    bit_nxt    = bit_r;
    wait_nxt   = wait_r;
    shift_nxt  = shift_r;
    acks_nxt   = acks_r;
    seen_nxt   = seen_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    advance    = 1'b0;
    done       = 1'b0;

    if (phase_r == PH_IDLE) begin
      if (q.cmd_valid) begin
        active_nxt = q.cmd;
        unique case (q.cmd)
          CMD_START: begin
            sda_nxt   = 1'b0;
            scl_nxt   = 1'b0;
            phase_nxt = PH_ST_W;
          end
          CMD_STOP: begin
            sda_nxt   = 1'b1;
            phase_nxt = PH_SP_D1;
            wait_nxt  = edge_delay;
          end
          CMD_WRITE: begin
            shift_nxt = q.tx_byte;
            bit_nxt   = {1'b0, BYTE_MSB};
            sda_nxt   = ~q.tx_byte[BYTE_MSB];
            phase_nxt = PH_WR_D1;
            wait_nxt  = edge_delay;
          end
          CMD_READ: begin
            acks_nxt  = q.send_ack;
            shift_nxt = '0;
            bit_nxt   = '0;
            sda_nxt   = 1'b0;
            scl_nxt   = 1'b0;
            phase_nxt = PH_RD_W;
          end
        endcase
      end
    end else if (is_wait) begin
      advance = q.scl_in;
    end else if (wait_r <= 16'd1) begin
      wait_nxt = '0;
      advance  = 1'b1;
    end else begin
      wait_nxt = wait_r - 16'd1;
    end

    if (advance) begin
      unique case (phase_r)
        PH_ST_W: begin
          phase_nxt = PH_ST_D1; wait_nxt = edge_delay;
        end
        PH_ST_D1: begin
          sda_nxt = 1'b1; phase_nxt = PH_ST_D2; wait_nxt = edge_delay;
        end
        PH_ST_D2: begin
          scl_nxt = 1'b1; phase_nxt = PH_ST_D3; wait_nxt = edge_delay;
        end
        PH_SP_D1: begin
          scl_nxt = 1'b0; phase_nxt = PH_SP_W;
        end
        PH_SP_W: begin
          phase_nxt = PH_SP_D2; wait_nxt = edge_delay;
        end
        PH_SP_D2: begin
          sda_nxt = 1'b0; phase_nxt = PH_SP_D3; wait_nxt = edge_delay;
        end
        PH_WR_D1: begin
          scl_nxt = 1'b0; phase_nxt = PH_WR_W;
        end
        PH_WR_W: begin
          phase_nxt = PH_WR_D2; wait_nxt = edge_delay;
        end
        PH_WR_D2: begin
          scl_nxt  = 1'b1;
          wait_nxt = edge_delay;
          if (bit_r[2:0] != 3'd0) begin
            bit_nxt   = {1'b0, bit_r[2:0] - 3'd1};
            sda_nxt   = ~shift_r[bit_nxt[2:0]];
            phase_nxt = PH_WR_D1;
          end else begin
            sda_nxt   = 1'b0;
            phase_nxt = PH_WR_AD1;
          end
        end
        PH_WR_AD1: begin
          scl_nxt = 1'b0; phase_nxt = PH_WR_AW;
        end
        PH_WR_AW: begin
          phase_nxt = PH_WR_AD2; wait_nxt = edge_delay;
        end
        PH_WR_AD2: begin
          seen_nxt = ~q.sda_in;
          scl_nxt  = 1'b1;
          done     = 1'b1;
        end
        PH_RD_W: begin
          phase_nxt = PH_RD_D1; wait_nxt = edge_delay;
        end
        PH_RD_D1: begin
          shift_nxt = {shift_r[6:0], q.sda_in};
          scl_nxt   = 1'b1;
          phase_nxt = PH_RD_D2;
          wait_nxt  = edge_delay;
        end
        PH_RD_D2: begin
          bit_nxt = bit_r + 4'd1;
          if (bit_nxt < BITS_PER_BYTE) begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_RD_W;
          end else begin
            sda_nxt   = acks_r;
            phase_nxt = PH_RD_AD1;
            wait_nxt  = edge_delay;
          end
        end
        PH_RD_AD1: begin
          scl_nxt = 1'b0; phase_nxt = PH_RD_AW;
        end
        PH_RD_AW: begin
          phase_nxt = PH_RD_AD2; wait_nxt = edge_delay;
        end
        PH_RD_AD2: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b0;
          done    = 1'b1;
        end
        default: begin
          done = 1'b1;
        end
      endcase
      if (done) begin
        phase_nxt = PH_IDLE;
      end
    end

    res.scl_pull_low = scl_nxt;
    res.sda_pull_low = sda_nxt;
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.done_res     = done;
    res.rx_byte      = (done && active_nxt == CMD_READ) ? shift_nxt : 8'd0;
    res.ack_received = done && (active_nxt == CMD_WRITE) && seen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      active_r    <= CMD_START;
      bit_r       <= '0;
      wait_r      <= '0;
      shift_r     <= '0;
      acks_r      <= 1'b0;
      seen_r      <= 1'b0;
      scl_r       <= 1'b0;
      sda_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r     <= phase_nxt;
        active_r    <= active_nxt;
        bit_r       <= bit_nxt;
        wait_r      <= wait_nxt;
        shift_r     <= shift_nxt;
        acks_r      <= acks_nxt;
        seen_r      <= seen_nxt;
        scl_r       <= scl_nxt;
        sda_r       <= sda_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/i2c_master_bit_sequencer.sv
// I2C master bit sequencer: each input transfer is one timer tick carrying an optional
// command and the sampled SCL and SDA levels, and each tick yields exactly one result
// transfer with the line drives, busy, a done pulse, the received byte and the ACK.
// A new tick is taken every clock while the queue has room. It enters a two-entry queue
// in the front end, is executed by the sequencer from the queue head, and its result
// is registered. The sequencer executes one tick per clock when the output side does
// not stall, limited by its single state update per tick. The edge delay
// register sits at byte address 0 and should be written only while no command runs.
module i2c_master_bit_sequencer
  import i2cms_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [15:0] edge_delay_r;
  q_head_t     head;
  logic        head_pop;
  reg_idx_t    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1]);
  assign prdata  = (reg_idx == REG_EDGE_DELAY) ? {16'd0, edge_delay_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_delay_r <= DELAY_RESET;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_EDGE_DELAY)) begin
      edge_delay_r <= pwdata[15:0];
    end
  end

  i2cms_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .head     (head),
    .head_pop (head_pop)
  );

  i2cms_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .edge_delay (edge_delay_r),
    .head       (head),
    .head_pop   (head_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import i2cms_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_AT        = 600;
  localparam int HOLD_CYCLES    = 120;
  localparam int SETTLE_CYCLES  = 4;
  localparam int RANDOM_TICKS   = 320;
  localparam logic [15:0] RAND_DELAYS [5] = '{16'd0, 16'd1, 16'd2, 16'd4, 16'd1};

  typedef enum logic [4:0] {
    PH_IDLE, ST_SCLW, ST_DLY1, ST_DLY2, ST_DLY3,
    SP_DLY1, SP_SCLW, SP_DLY2, SP_DLY3,
    WR_DLY1, WR_SCLW, WR_DLY2, WR_ACK_DLY1, WR_ACK_SCLW, WR_ACK_DLY2,
    RD_SCLW, RD_DLY1, RD_DLY2, RD_ACK_DLY1, RD_ACK_SCLW, RD_ACK_DLY2
  } seq_phase_t;

  class i2c_tick_scoreboard;
    logic [15:0] edge_delay;
    seq_phase_t  ph;
    cmd_t        cur_cmd;
    logic [3:0]  bit_idx;
    logic [15:0] wait_left;
    logic [7:0]  shreg;
    logic        ack_out;
    logic        ack_seen;
    logic        scl_dr;
    logic        sda_dr;
    out_item_t   expected_q[$];
    int          errors;

    function new();
      edge_delay = DELAY_RESET;
      ph = PH_IDLE;
      cur_cmd = CMD_START;
      bit_idx = '0;
      wait_left = '0;
      shreg = '0;
      ack_out = 1'b0;
      ack_seen = 1'b0;
      scl_dr = 1'b0;
      sda_dr = 1'b0;
      errors = 0;
    endfunction

    function bit busy();
      return ph != PH_IDLE;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function void set_delay(input logic [15:0] v);
      edge_delay = v;
    endfunction

    function void arm(input seq_phase_t nxt);
      ph = nxt;
      wait_left = edge_delay;
    endfunction

    function void note_tick(input in_item_t t);
      out_item_t r;
      bit fin;
      bit adv;
      fin = 1'b0;
      adv = 1'b0;
      if (ph == PH_IDLE) begin
        if (t.command_valid) begin
          cur_cmd = cmd_t'(t.command);
          case (cur_cmd)
            CMD_START: begin
              sda_dr = 1'b0;
              scl_dr = 1'b0;
              ph = ST_SCLW;
            end
            CMD_STOP: begin
              sda_dr = 1'b1;
              arm(SP_DLY1);
            end
            CMD_WRITE: begin
              shreg = t.tx_byte;
              bit_idx = {1'b0, BYTE_MSB};
              sda_dr = ~shreg[BYTE_MSB];
              arm(WR_DLY1);
            end
            default: begin
              ack_out = t.send_ack;
              shreg = '0;
              bit_idx = '0;
              sda_dr = 1'b0;
              scl_dr = 1'b0;
              ph = RD_SCLW;
            end
          endcase
        end
      end else if (ph inside {ST_SCLW, SP_SCLW, WR_SCLW, WR_ACK_SCLW, RD_SCLW, RD_ACK_SCLW}) begin
        adv = t.scl_in;
      end else if (wait_left <= 16'd1) begin
        wait_left = '0;
        adv = 1'b1;
      end else begin
        wait_left = wait_left - 16'd1;
      end

      if (adv) begin
        case (ph)
          ST_SCLW: arm(ST_DLY1);
          ST_DLY1: begin
            sda_dr = 1'b1;
            arm(ST_DLY2);
          end
          ST_DLY2: begin
            scl_dr = 1'b1;
            arm(ST_DLY3);
          end
          SP_DLY1: begin
            scl_dr = 1'b0;
            ph = SP_SCLW;
          end
          SP_SCLW: arm(SP_DLY2);
          SP_DLY2: begin
            sda_dr = 1'b0;
            arm(SP_DLY3);
          end
          WR_DLY1: begin
            scl_dr = 1'b0;
            ph = WR_SCLW;
          end
          WR_SCLW: arm(WR_DLY2);
          WR_DLY2: begin
            scl_dr = 1'b1;
            if (bit_idx[2:0] != 3'd0) begin
              bit_idx = {1'b0, bit_idx[2:0] - 3'd1};
              sda_dr = ~shreg[bit_idx[2:0]];
              arm(WR_DLY1);
            end else begin
              sda_dr = 1'b0;
              arm(WR_ACK_DLY1);
            end
          end
          WR_ACK_DLY1: begin
            scl_dr = 1'b0;
            ph = WR_ACK_SCLW;
          end
          WR_ACK_SCLW: arm(WR_ACK_DLY2);
          WR_ACK_DLY2: begin
            ack_seen = ~t.sda_in;
            scl_dr = 1'b1;
            fin = 1'b1;
          end
          RD_SCLW: arm(RD_DLY1);
          RD_DLY1: begin
            shreg = {shreg[6:0], t.sda_in};
            scl_dr = 1'b1;
            arm(RD_DLY2);
          end
          RD_DLY2: begin
            bit_idx = bit_idx + 4'd1;
            if (bit_idx < BITS_PER_BYTE) begin
              scl_dr = 1'b0;
              ph = RD_SCLW;
            end else begin
              sda_dr = ack_out;
              arm(RD_ACK_DLY1);
            end
          end
          RD_ACK_DLY1: begin
            scl_dr = 1'b0;
            ph = RD_ACK_SCLW;
          end
          RD_ACK_SCLW: arm(RD_ACK_DLY2);
          RD_ACK_DLY2: begin
            scl_dr = 1'b1;
            sda_dr = 1'b0;
            fin = 1'b1;
          end
          default: fin = 1'b1;
        endcase
        if (fin) ph = PH_IDLE;
      end

      r.scl_pull_low = scl_dr;
      r.sda_pull_low = sda_dr;
      r.busy_res = (ph != PH_IDLE);
      r.done_res = fin;
      r.rx_byte = (fin && cur_cmd == CMD_READ) ? shreg : 8'h00;
      r.ack_received = fin && cur_cmd == CMD_WRITE && ack_seen;
      expected_q.push_back(r);
    endfunction

    function void cmp(input string name, input logic [7:0] exp, input logic [7:0] got);
      if (got !== exp) begin
        errors++;
        $error("%s: expected %0h, got %0h", name, exp, got);
      end
    endfunction

    function void check_result(input out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result transfer with nothing expected: %p", got);
        return;
      end
      exp = expected_q.pop_front();
      cmp("scl_pull_low", exp.scl_pull_low, got.scl_pull_low);
      cmp("sda_pull_low", exp.sda_pull_low, got.sda_pull_low);
      cmp("busy_res", exp.busy_res, got.busy_res);
      cmp("done_res", exp.done_res, got.done_res);
      cmp("rx_byte", exp.rx_byte, got.rx_byte);
      cmp("ack_received", exp.ack_received, got.ack_received);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  i2c_tick_scoreboard sb;
  bit gaps_on = 1'b1;
  int results_seen = 0;
  int fails = 0;
  int idle_cycles = 0;

  i2c_master_bit_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #4 clk = ~clk;

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic in_item_t make_tick(input bit offer, input bit scl_low);
    in_item_t t;
    t.command_valid = offer;
    t.command = 2'($urandom_range(0, 3));
    t.tx_byte = 8'($urandom_range(0, 255));
    t.send_ack = 1'($urandom_range(0, 1));
    t.scl_in = ~scl_low;
    t.sda_in = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic send_tick(input in_item_t t);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(t);
  endtask

  task automatic run_command(input cmd_t c, input logic [7:0] txb, input logic sack,
                             input int sda_mode, input bit hold, input int stretch_pct);
    in_item_t t;
    bit first;
    first = 1'b1;
    while (first || sb.busy()) begin
      t = make_tick(first || hold, $urandom_range(1, 100) <= stretch_pct);
      t.command = c;
      t.tx_byte = txb;
      t.send_ack = sack;
      if (sda_mode < 2) t.sda_in = sda_mode[0];
      send_tick(t);
      first = 1'b0;
    end
  endtask

  task automatic random_ticks(input int n);
    in_item_t t;
    bit offer;
    int low_run;
    low_run = 0;
    repeat (n) begin
      if (sb.busy()) offer = ($urandom_range(0, 15) == 0);
      else offer = ($urandom_range(0, 2) == 0);
      t = make_tick(offer, low_run > 0 || $urandom_range(0, 7) == 0);
      if (low_run > 0) low_run--;
      else if (sb.busy() && $urandom_range(0, 63) == 0) low_run = $urandom_range(4, 24);
      send_tick(t);
    end
  endtask

  task automatic settle();
    while (sb.busy()) send_tick(make_tick(1'b0, 1'b0));
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic read_delay(output logic [31:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_W'(4 * REG_EDGE_DELAY);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_delay(input logic [15:0] v);
    logic [31:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * REG_EDGE_DELAY);
    pwdata <= {16'h0000, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_delay(v);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[15:0] !== v) begin
      fails++;
      $error("edge_delay_ticks: expected %0d, got %0d", v, rd[15:0]);
    end
  endtask

  initial begin : result_sink
    int gap;
    forever begin
      if (results_seen == HOLD_AT) gap = HOLD_CYCLES;
      else gap = gaps_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_seen++;
      sb.check_result(out_data);
    end
  end

  initial begin : stimulus
    logic [31:0] rd0;
    sb = new();
    wait (rst_n);
    @(posedge clk);

    // The delay register must read its reset value before any write.
    read_delay(rd0);
    if (rd0[15:0] !== DELAY_RESET) begin
      fails++;
      $error("edge_delay_ticks: expected %0d, got %0d", DELAY_RESET, rd0[15:0]);
    end
    write_delay(16'd1);

    run_command(CMD_START, 8'h00, 1'b0, 2, 1'b1, 0);
    run_command(CMD_WRITE, 8'h00, 1'b0, 0, 1'b0, 0);
    run_command(CMD_WRITE, 8'hFF, 1'b1, 1, 1'b0, 0);
    run_command(CMD_WRITE, 8'hA5, 1'b0, 2, 1'b1, 50);
    run_command(CMD_READ, 8'h00, 1'b1, 1, 1'b0, 0);
    run_command(CMD_READ, 8'hFF, 1'b0, 0, 1'b1, 0);
    run_command(CMD_READ, 8'h3C, 1'b1, 2, 1'b0, 60);
    run_command(CMD_STOP, 8'h00, 1'b0, 2, 1'b1, 30);
    run_command(CMD_STOP, 8'h00, 1'b1, 2, 1'b0, 0);

    for (int i = 0; i < 5; i++) begin
      settle();
      gaps_on = (i != 3);
      write_delay(RAND_DELAYS[i]);
      random_ticks(RANDOM_TICKS);
    end

    // The largest delay value is only written and read back.
    settle();
    write_delay(16'hFFFF);
    settle();

    if (sb.errors == 0 && fails == 0 && sb.outstanding() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/i2cms_pkg.sv
sv/i2cms_front.sv
sv/i2cms_back.sv
sv/i2c_master_bit_sequencer.sv
tb/sv/tb_top.sv
